// ===== src/sws_pkg.sv =====
// ----------------------------------------------------------------------------
// sws_pkg
// Shared types and constants for the LIFO stack with search: item structs,
// operation and status codes, and the controller/datapath command bundles.
// ----------------------------------------------------------------------------
package sws_pkg;

  // Default number of stack entries
  localparam int SWS_DEPTH = 16;

  // Word width of a stack entry
  localparam int WORD_W = 32;

  // Operation codes carried in the func field
  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_SEARCH = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_MISS  = 2'd3
  } status_t;

  // One input item
  typedef struct packed {
    logic [1:0]               func;
    logic signed [WORD_W-1:0] value;
  } in_item_t;

  // One result item
  typedef struct packed {
    logic [1:0]               status;
    logic signed [WORD_W-1:0] popped_value;
    logic [4:0]               position;
    logic [4:0]               entry_count;
  } out_item_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic    capture;     // latch the accepted input item
    logic    push;        // write the top slot, count up
    logic    pop;         // count down, read the old top
    logic    scan_start;  // read the top entry, position 1
    logic    scan_step;   // read the next entry down, position up
    logic    res_we;      // record the result status
    status_t res_status;
    logic    take_pop;    // result carries the word read from the store
    logic    keep_pos;    // result carries the scan position
    logic    load_out;    // move the result into the output register
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    op_t  op;     // operation of the held item
    logic empty;  // no entries held
    logic full;   // every entry held
    logic match;  // word read from the store equals the search word
    logic last;   // scan has reached the bottom entry
  } stat_t;

endpackage : sws_pkg

// ===== src/sws_ram.sv =====
// ----------------------------------------------------------------------------
// sws_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module sws_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule : sws_ram

// ===== src/sws_ctrl.sv =====
// ----------------------------------------------------------------------------
// sws_ctrl
// Controller for the stack: takes one item at a time, sequences the store
// accesses for push, pop and search, and hands the result to the output.
// ----------------------------------------------------------------------------
module sws_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output sws_pkg::cmd_t cmd,
  input  sws_pkg::stat_t stat
);
  import sws_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_READ,
    S_SCAN,
    S_LOAD
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // Next state and commands
  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.res_we     = 1'b1;
        cmd.res_status = ST_OK;
        state_nxt      = S_LOAD;
        unique case (stat.op)
          OP_PUSH: begin
            if (stat.full) begin
              cmd.res_status = ST_FULL;
            end else begin
              cmd.push = 1'b1;
            end
          end
          OP_POP: begin
            if (stat.empty) begin
              cmd.res_status = ST_EMPTY;
            end else begin
              cmd.pop    = 1'b1;
              cmd.res_we = 1'b0;
              state_nxt  = S_READ;
            end
          end
          OP_SEARCH: begin
            if (stat.empty) begin
              cmd.res_status = ST_EMPTY;
            end else begin
              cmd.scan_start = 1'b1;
              cmd.res_we     = 1'b0;
              state_nxt      = S_SCAN;
            end
          end
          default: begin
            // unused code: no operation, plain ok result
          end
        endcase
      end
      S_READ: begin
        cmd.res_we     = 1'b1;
        cmd.res_status = ST_OK;
        cmd.take_pop   = 1'b1;
        state_nxt      = S_LOAD;
      end
      S_SCAN: begin
        if (stat.match) begin
          cmd.res_we     = 1'b1;
          cmd.res_status = ST_OK;
          cmd.keep_pos   = 1'b1;
          state_nxt      = S_LOAD;
        end else if (stat.last) begin
          cmd.res_we     = 1'b1;
          cmd.res_status = ST_MISS;
          state_nxt      = S_LOAD;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_LOAD: begin
        if (!out_valid_r || !out_stall) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  // A new result never overwrites one still waiting downstream
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || !out_stall))
    else $error("result loaded over an untaken result");

  // After a transfer in, the next item waits until this one is done
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second item taken while one is in progress");

  // Only one store access is commanded at a time
  a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.push, cmd.pop, cmd.scan_start, cmd.scan_step}))
    else $error("conflicting store commands");

endmodule : sws_ctrl

// ===== src/sws_dp.sv =====
// ----------------------------------------------------------------------------
// sws_dp
// Datapath for the stack: entry count, scan pointer and position counters,
// the word store, result registers and the output register.
// ----------------------------------------------------------------------------
module sws_dp #(
  parameter int DEPTH = sws_pkg::SWS_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  sws_pkg::in_item_t  in_data,
  input  sws_pkg::cmd_t      cmd,
  output sws_pkg::stat_t     stat,
  output sws_pkg::out_item_t out_data
);
  import sws_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [1:0]               op_r;
  logic signed [WORD_W-1:0] value_r;
  logic [CW-1:0]            count_r;
  logic [AW-1:0]            ptr_r;
  logic [CW-1:0]            pos_r;
  status_t                  status_r;
  logic signed [WORD_W-1:0] popped_r;
  logic [CW-1:0]            res_pos_r;
  out_item_t                out_r;

  logic [CW-1:0]     count_dec;
  logic [AW-1:0]     top_addr;
  logic [AW-1:0]     raddr;
  logic              we;
  logic [WORD_W-1:0] rdata;
  logic [CW+4:0]     count_ext;
  logic [CW+4:0]     pos_ext;

  assign count_dec = count_r - CW'(1);
  assign top_addr  = count_dec[AW-1:0];
  assign we        = cmd.push;

  // Read address: top entry for pop and scan start, next one down on a step
  always_comb begin
    raddr = ptr_r;
    if (cmd.pop || cmd.scan_start) begin
      raddr = top_addr;
    end else if (cmd.scan_step) begin
      raddr = ptr_r - AW'(1);
    end
  end

  sws_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (count_r[AW-1:0]),
    .wdata (value_r),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Entry count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.push) begin
      count_r <= count_r + CW'(1);
    end else if (cmd.pop) begin
      count_r <= count_dec;
    end
  end

  // Held item, scan pointer and position
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= in_data.func;
      value_r <= in_data.value;
    end
    if (cmd.scan_start) begin
      ptr_r <= top_addr;
      pos_r <= CW'(1);
    end else if (cmd.scan_step) begin
      ptr_r <= ptr_r - AW'(1);
      pos_r <= pos_r + CW'(1);
    end
  end

  // Result fields
  always_ff @(posedge clk) begin
    if (cmd.res_we) begin
      status_r  <= cmd.res_status;
      popped_r  <= cmd.take_pop ? $signed(rdata) : '0;
      res_pos_r <= cmd.keep_pos ? pos_r : '0;
    end
  end

  // Position and count are reported modulo 32
  assign count_ext = {5'b0, count_r};
  assign pos_ext   = {5'b0, res_pos_r};

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_r.status       <= status_r;
      out_r.popped_value <= popped_r;
      out_r.position     <= pos_ext[4:0];
      out_r.entry_count  <= count_ext[4:0];
    end
  end

  assign out_data = out_r;

  // Status back to the controller
  assign stat.op    = op_t'(op_r);
  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == CW'(DEPTH));
  assign stat.match = (rdata == value_r);
  assign stat.last  = (ptr_r == '0);

  // The count never runs past the store
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count beyond depth");

  // Push only with room, pop only with an entry
  a_push_pop_legal: assert property (@(posedge clk) disable iff (!rst_n)
    (!cmd.push || !stat.full) && (!cmd.pop || !stat.empty))
    else $error("push when full or pop when empty");

  // A scan step never goes below the bottom entry
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_step |-> (ptr_r != '0))
    else $error("scan stepped past bottom");

endmodule : sws_dp

// ===== src/stack_with_search.sv =====
// Sequence: each item is captured and decoded; push, refused operations and
//   no-op then load their result, a pop first reads the old top word, and a
//   search first compares entries from the top down, one per cycle through the
//   store's single registered read port. One item at a time: the next item is
//   taken only after the result moves into the output register.
// Reset (rst_n low, synchronous) empties the stack; store words are not cleared.
// ----------------------------------------------------------------------------
// stack_with_search
// LIFO stack of signed 32-bit words with push, pop and search from the top.
// ----------------------------------------------------------------------------
module stack_with_search #(
  parameter int DEPTH = sws_pkg::SWS_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  sws_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output sws_pkg::out_item_t out_data
);
  import sws_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Sequencer
  sws_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  // Store, counters and result registers
  sws_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule : stack_with_search
